>>> src/tbt_pkg.sv
// Shared types and constants of the touch baseline tracker.
// No dependencies; imported by every module of the block.
package tbt_pkg;

  localparam int unsigned PAD_COUNT_DEF  = 3;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned MARGIN_W = 8;
  localparam int unsigned SLACK_W  = 8;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned CFG_W    = PERIOD_W;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(15);
  localparam logic [SLACK_W-1:0]  SLACK_RST  = SLACK_W'(2);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(15);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef enum logic [1:0] {
    CFG_MARGIN = 2'd0,
    CFG_SLACK  = 2'd1,
    CFG_PERIOD = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE    = 1'b0,
    OP_CALIBRATE = 1'b1
  } op_e;

  // Per-pad control shared by all pad cells.
  typedef struct packed {
    op_e                 op;
    logic                update;
    logic [MARGIN_W-1:0] margin;
    logic [SLACK_W-1:0]  slack;
  } pad_ctrl_t;

endpackage

>>> src/touch_baseline_tracker_top.sv
// Top level of the touch baseline tracker: input register, pad cells, timer,
// key flags and result register. Depends on tbt_pkg, tbt_pad and tbt_timer.
//
// Usage:
//   Input stream s_*: one transfer per sample set. s_tuser_i[0] is the op
//   (0 = sample, 1 = calibrate); s_tdata_i carries the pad counts and the
//   per-pad key clear mask. Output stream m_*: one result transfer per input
//   transfer, with touched mask, sticky key mask and updated references.
//   An input transfer passes the input register and then the result register
//   before its result is valid; throughput is one item per cycle while
//   m_tready_i is high, set by the combinational pad update between them (state
//   is written as the result is registered, so the next item sees it at once).
//   Configuration: cfg_we_i writes register cfg_idx_i (0 margin, 1 slack,
//   2 update period) with cfg_wdata_i; write only while the block is idle.
//   Reset: references, key flags and period counter clear, registers take
//   their defaults (15, 2, 15), both streams empty.
//   Stall: when m_tready_i is low the result holds; one more item waits in
//   the input register, then s_tready_o drops until the result is taken.
module touch_baseline_tracker_top #(
  parameter int unsigned PAD_COUNT  = tbt_pkg::PAD_COUNT_DEF,
  parameter int unsigned COUNT_BITS = tbt_pkg::COUNT_BITS_DEF,
  localparam int unsigned IN_BITS   = PAD_COUNT * COUNT_BITS + PAD_COUNT,
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS  = 2 * PAD_COUNT + PAD_COUNT * COUNT_BITS,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tbt_pkg::CFG_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [IN_W-1:0]            s_tdata_i,  // sample per pad (pad 0 first), clear_mask
  input  logic [0:0]                 s_tuser_i,  // op
  // output stream
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [OUT_W-1:0]           m_tdata_o   // touched_mask, key_mask, ref per pad (pad 0 first)
);
  import tbt_pkg::*;

  // config registers
  logic [MARGIN_W-1:0] margin_q;
  logic [SLACK_W-1:0]  slack_q;
  logic [PERIOD_W-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RST;
      slack_q  <= SLACK_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_MARGIN: margin_q <= cfg_wdata_i[MARGIN_W-1:0];
        CFG_SLACK:  slack_q  <= cfg_wdata_i[SLACK_W-1:0];
        CFG_PERIOD: period_q <= cfg_wdata_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_vld_q;
  logic out_vld_q;
  logic out_free;
  logic advance;
  logic in_xfer;

  assign out_free   = !out_vld_q || m_tready_i;
  assign advance    = in_vld_q && out_free;
  assign s_tready_o = !in_vld_q || out_free;
  assign in_xfer    = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input register
  op_e                                    op_q;
  logic [PAD_COUNT-1:0][COUNT_BITS-1:0]   smp_q;
  logic [PAD_COUNT-1:0]                   clr_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_e'(s_tuser_i[0]);
      smp_q <= s_tdata_i[PAD_COUNT*COUNT_BITS-1:0];
      clr_q <= s_tdata_i[IN_BITS-1:PAD_COUNT*COUNT_BITS];
    end
  end

  // timer
  logic update;

  tbt_timer u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance && (op_q == OP_SAMPLE)),
    .period_i (period_q),
    .update_o (update)
  );

  // pad cells
  pad_ctrl_t                            ctrl;
  logic [PAD_COUNT-1:0][COUNT_BITS-1:0] refs_q, refs_d;
  logic [PAD_COUNT-1:0]                 touched;
  logic [PAD_COUNT-1:0]                 key_q, key_d;

  assign ctrl = '{op: op_q, update: update, margin: margin_q, slack: slack_q};

  for (genvar p = 0; p < PAD_COUNT; p++) begin : g_pad
    tbt_pad #(
      .COUNT_BITS (COUNT_BITS)
    ) u_pad (
      .ctrl_i    (ctrl),
      .sample_i  (smp_q[p]),
      .ref_i     (refs_q[p]),
      .ref_o     (refs_d[p]),
      .touched_o (touched[p])
    );
  end

  assign key_d = (key_q & ~clr_q) | touched;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refs_q <= '0;
      key_q  <= '0;
    end else if (advance) begin
      refs_q <= refs_d;
      key_q  <= key_d;
    end
  end

  // result register
  logic [OUT_BITS-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= {refs_d, key_d, touched};
    end
  end

  assign m_tvalid_o = out_vld_q;

  always_comb begin
    m_tdata_o                 = '0;
    m_tdata_o[OUT_BITS-1:0]   = res_q;
  end

endmodule

>>> src/tbt_pad.sv
// Reference update and touch compare for one pad.
// Depends on tbt_pkg.
module tbt_pad #(
  parameter int unsigned COUNT_BITS = tbt_pkg::COUNT_BITS_DEF
) (
  input  tbt_pkg::pad_ctrl_t    ctrl_i,
  input  logic [COUNT_BITS-1:0] sample_i,
  input  logic [COUNT_BITS-1:0] ref_i,
  output logic [COUNT_BITS-1:0] ref_o,
  output logic                  touched_o
);
  import tbt_pkg::*;

  logic [COUNT_BITS-1:0] margin_ext;
  logic [COUNT_BITS-1:0] below;
  logic [COUNT_BITS-1:0] gap;
  logic [COUNT_BITS:0]   limit;
  logic                  above;

  assign margin_ext = COUNT_BITS'(ctrl_i.margin);
  assign below      = (sample_i > margin_ext) ? (sample_i - margin_ext) : '0;
  assign gap        = ref_i - sample_i;
  assign limit      = (COUNT_BITS+1)'(ctrl_i.margin) + (COUNT_BITS+1)'(ctrl_i.slack);
  assign above      = ref_i > sample_i;

  always_comb begin
    ref_o     = ref_i;
    touched_o = 1'b0;
    if (ctrl_i.op == OP_CALIBRATE) begin
      ref_o = below;
    end else if (above) begin
      touched_o = 1'b1;
      if ({1'b0, gap} > limit) begin
        ref_o = ref_i - COUNT_BITS'(1);
      end
    end else if (ctrl_i.update) begin
      if (below >= ref_i) begin
        ref_o = below;
      end else begin
        ref_o = ref_i - COUNT_BITS'(1);
      end
    end
  end

endmodule

>>> src/tbt_timer.sv
// Update period counter; flags the sample item on which untouched pads re-center or step down.
// Depends on tbt_pkg.
module tbt_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [tbt_pkg::PERIOD_W-1:0]  period_i,
  output logic                          update_o
);
  import tbt_pkg::*;

  logic [PERIOD_W-1:0] cnt_q, cnt_d;

  assign update_o = cnt_q > period_i;

  always_comb begin
    cnt_d = cnt_q;
    if (step_i) begin
      if (update_o) begin
        cnt_d = '0;
      end else if (cnt_q < PERIOD_MAX) begin
        cnt_d = cnt_q + PERIOD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> test/touch_baseline_tracker_top_test.sv
// Testbench of touch_baseline_tracker_top: random and directed sample sets against
// an in-bench tracker model, with stream stalls and register changes.
// Depends on tbt_pkg and touch_baseline_tracker_top.
`timescale 1ns / 1ps

module touch_baseline_tracker_top_test;
  import tbt_pkg::*;

  localparam int unsigned PADS        = PAD_COUNT_DEF;
  localparam int unsigned CNT_W       = COUNT_BITS_DEF;
  localparam int unsigned IN_W        = 56;
  localparam int unsigned OUT_W       = 56;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0]  CFG_SPARE   = 2'd3;

  // touched_mask in the lowest bits, then key_mask, then refs (pad 0 first)
  typedef struct packed {
    logic [PADS-1:0][CNT_W-1:0]  refs;
    logic [PADS-1:0]             keys;
    logic [PADS-1:0]             touched;
  } tracker_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = '0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               s_tvalid_i  = 1'b0;
  logic               s_tready_o;
  logic [IN_W-1:0]    s_tdata_i   = '0;
  logic [0:0]         s_tuser_i   = '0;
  logic               m_tvalid_o;
  logic               m_tready_i  = 1'b0;
  logic [OUT_W-1:0]   m_tdata_o;

  touch_baseline_tracker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // tracker model state
  logic [PADS-1:0][CNT_W-1:0] base_ref;
  logic [PADS-1:0]            key_q;
  logic [PERIOD_W-1:0]        period_cnt;
  logic [MARGIN_W-1:0]        margin_q;
  logic [SLACK_W-1:0]         slack_q;
  logic [PERIOD_W-1:0]        period_q;

  tracker_result_t pending_results[$];
  int unsigned     mismatch_cnt = 0;
  int unsigned     cycle_cnt    = 0;
  bit              tx_idle      = 1'b1;
  bit              rx_idle      = 1'b1;
  int unsigned     hold_reqs    = 0;
  int unsigned     holds_done   = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic tracker_result_t step_tracker(input op_e op,
                                                   input logic [PADS-1:0][CNT_W-1:0] cnt,
                                                   input logic [PADS-1:0] clr);
    tracker_result_t res;
    logic            upd;
    int unsigned     i;
    int unsigned     d;
    upd = 1'b0;
    res.touched = '0;
    key_q &= ~clr;
    if (op == OP_CALIBRATE) begin
      for (i = 0; i < PADS; i++) begin
        base_ref[i] = (cnt[i] > margin_q) ? cnt[i] - margin_q : '0;
      end
    end else begin
      if (period_cnt > period_q) begin
        upd = 1'b1;
        period_cnt = '0;
      end else if (period_cnt < PERIOD_MAX) begin
        period_cnt++;
      end
      for (i = 0; i < PADS; i++) begin
        if (base_ref[i] > cnt[i]) begin
          res.touched[i] = 1'b1;
          key_q[i] = 1'b1;
          if (int'(base_ref[i]) - int'(cnt[i]) > int'(margin_q) + int'(slack_q)) begin
            base_ref[i]--;
          end
        end else if (upd) begin
          d = (cnt[i] > margin_q) ? int'(cnt[i]) - int'(margin_q) : 0;
          if (d >= base_ref[i]) base_ref[i] = d[CNT_W-1:0];
          else base_ref[i]--;
        end
      end
    end
    res.keys = key_q;
    res.refs = base_ref;
    return res;
  endfunction

  // count near the current reference so touches, holds and drift all occur
  function automatic logic [CNT_W-1:0] pick_count(input int unsigned pad);
    int v;
    int base;
    base = int'(base_ref[pad]);
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 16'hFFFF));
      1, 2, 3, 4: v = base + int'(margin_q) + int'($urandom_range(0, 8)) - 4;
      5, 6, 7: v = base - int'($urandom_range(1, int'(margin_q) + int'(slack_q) + 4));
      default: v = base + int'($urandom_range(0, 600));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[CNT_W-1:0];
  endfunction

  task automatic send_item(input op_e op, input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b,
                           input logic [CNT_W-1:0] c, input logic [PADS-1:0] clr);
    int unsigned                gap;
    logic [PADS-1:0][CNT_W-1:0] cnt;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {5'b0, clr, c, b, a};
    do @(posedge clk_i); while (!s_tready_o);
    cnt = {c, b, a};
    pending_results.push_back(step_tracker(op, cnt, clr));
  endtask

  // drain the block before touching its registers
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_MARGIN: margin_q = val[MARGIN_W-1:0];
      CFG_SLACK:  slack_q  = val[SLACK_W-1:0];
      CFG_PERIOD: period_q = val;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(OP_SAMPLE,    16'h0000, 16'hFFFF, 16'h1234, 3'b000);
    send_item(OP_CALIBRATE, 16'h0000, 16'h000A, 16'hFFFF, 3'b111);
    send_item(OP_SAMPLE,    16'h0000, 16'h0000, 16'h0000, 3'b000);
    // gap exactly margin plus slack, then one more
    send_item(OP_SAMPLE,    16'h0000, 16'h0000, 16'hFFDE, 3'b000);
    send_item(OP_SAMPLE,    16'h0000, 16'h0000, 16'hFFDD, 3'b000);
    send_item(OP_SAMPLE,    16'h0000, 16'h0000, 16'hFFDD, 3'b100);
    settle();
    write_reg(CFG_PERIOD, 10'd0);
    send_item(OP_SAMPLE,    16'h0000, 16'h0000, 16'hFFFF, 3'b100);
    send_item(OP_CALIBRATE, 16'd115,  16'd20,   16'hFFFF, 3'b000);
    send_item(OP_SAMPLE,    16'd105,  16'd5,    16'hFFFF, 3'b000);
    // update: one pad re-centers, others step down, one saturates
    send_item(OP_SAMPLE,    16'd105,  16'd5,    16'hFFFF, 3'b000);
    settle();
    write_reg(CFG_MARGIN, 10'd0);
    write_reg(CFG_SLACK, 10'd0);
    send_item(OP_SAMPLE,    16'd98,   16'd4,    16'hFFF0, 3'b000);
    send_item(OP_SAMPLE,    16'd200,  16'd4,    16'hFFEF, 3'b000);
    settle();
    write_reg(CFG_MARGIN, 10'd255);
    write_reg(CFG_SLACK, 10'd255);
    send_item(OP_CALIBRATE, 16'd254,  16'd255,  16'h01FF, 3'b000);
    send_item(OP_SAMPLE,    16'h0000, 16'h0000, 16'h0000, 3'b000);
    send_item(OP_SAMPLE,    16'h0000, 16'h0000, 16'h0000, 3'b111);
    settle();
    write_reg(CFG_SPARE, 10'h3FF);
    write_reg(CFG_PERIOD, 10'h3FF);
    write_reg(CFG_MARGIN, 10'h3F0);
    send_item(OP_SAMPLE,    16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000);
    send_item(OP_CALIBRATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b010);
    send_item(OP_SAMPLE,    16'h0000, 16'hAAAA, 16'h5555, 3'b101);
    settle();
    write_reg(CFG_MARGIN, 10'(MARGIN_RST));
    write_reg(CFG_SLACK, 10'(SLACK_RST));
    write_reg(CFG_PERIOD, PERIOD_RST);
  endtask

  task automatic run_random_items(input int unsigned n);
    int unsigned k;
    op_e         op;
    logic [2:0]  clr;
    for (k = 0; k < n; k++) begin
      op  = (k == 0 || $urandom_range(0, 24) == 0) ? OP_CALIBRATE : OP_SAMPLE;
      clr = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
      send_item(op, pick_count(0), pick_count(1), pick_count(2), clr);
    end
  endtask

  task automatic test_random();
    int unsigned ph;
    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_MARGIN, 10'd15);
          write_reg(CFG_SLACK, 10'd2);
          write_reg(CFG_PERIOD, 10'd3);
        end
        1: begin
          write_reg(CFG_MARGIN, 10'd0);
          write_reg(CFG_SLACK, 10'd0);
          write_reg(CFG_PERIOD, 10'd0);
        end
        2: begin
          write_reg(CFG_MARGIN, 10'd255);
          write_reg(CFG_SLACK, 10'd255);
          write_reg(CFG_PERIOD, 10'd1);
        end
        3: begin
          write_reg(CFG_MARGIN, 10'($urandom_range(0, 1023)));
          write_reg(CFG_SLACK, 10'($urandom_range(0, 1023)));
          write_reg(CFG_PERIOD, 10'd1023);
        end
        default: begin
          write_reg(CFG_MARGIN, 10'($urandom_range(0, 80)));
          write_reg(CFG_SLACK, 10'($urandom_range(0, 40)));
          write_reg(CFG_PERIOD, 10'($urandom_range(0, 12)));
        end
      endcase
      tx_idle = (ph % 3) != 2;
      rx_idle = (ph % 4) != 3;
      run_random_items(50);
    end
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(CFG_PERIOD, 10'd2);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_reqs <= hold_reqs + 1;
    run_random_items(40);
    tx_idle = 1'b1;
  endtask

  // result sink: random stalls after each transfer, long hold on request
  initial begin : result_sink
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_tready_i <= 1'b1;
      end else if (m_tvalid_o && m_tready_i) begin
        w = rx_idle ? $urandom_range(0, 9) : 0;
        if (w > 0) begin
          m_tready_i <= 1'b0;
          repeat (w) @(posedge clk_i);
          m_tready_i <= 1'b1;
        end
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    tracker_result_t got;
    tracker_result_t exp;
    int unsigned     i;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = m_tdata_o[$bits(tracker_result_t)-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no expectation", got));
      end else begin
        exp = pending_results.pop_front();
        if (got.touched !== exp.touched)
          report_mismatch($sformatf("touched_mask %b, expected %b", got.touched, exp.touched));
        if (got.keys !== exp.keys)
          report_mismatch($sformatf("key_mask %b, expected %b", got.keys, exp.keys));
        for (i = 0; i < PADS; i++) begin
          if (got.refs[i] !== exp.refs[i])
            report_mismatch($sformatf("ref of pad %0d %h, expected %h", i, got.refs[i],
                                      exp.refs[i]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    base_ref   = '0;
    key_q      = '0;
    period_cnt = '0;
    margin_q   = MARGIN_RST;
    slack_q    = SLACK_RST;
    period_q   = PERIOD_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    settle();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) report_mismatch("expectations left over");
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> touch_baseline_tracker_top.f
src/tbt_pkg.sv
src/tbt_pad.sv
src/tbt_timer.sv
src/touch_baseline_tracker_top.sv
test/touch_baseline_tracker_top_test.sv
